[design/scr_pkg.sv]
// ---------------------------------------------------------------------------
// scr_pkg
// Shared types and constants of the servo command receiver.
// ---------------------------------------------------------------------------
package scr_pkg;

   // item operation codes
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_POLL = 2'd2
   } op_type;

   // frame markers and reset values
   localparam logic [7:0]  FRAME_START   = 8'h48;  // 'H'
   localparam logic [7:0]  FRAME_END     = 8'h52;  // 'R'
   localparam logic [15:0] RESET_TARGET  = 16'd1000;
   localparam logic [15:0] RESET_CURRENT = 16'd1520;

   // only the first four frame bytes are ever inspected
   localparam int CHECK_BYTES = 4;
   localparam int BUF_IDX_W   = 2;

   // one input item held in the input register
   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
   } item_type;

   // per-item event flags from the frame logic
   typedef struct packed {
      logic frame_accepted;
      logic partial_cleared;
   } frame_event_type;

endpackage

[design/scr_frame.sv]
// ---------------------------------------------------------------------------
// scr_frame
// Frame collector: byte buffer, byte counter, idle flag and target width.
// ---------------------------------------------------------------------------
module scr_frame #(
   parameter int FRAME_LENGTH = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  scr_pkg::item_type        item,
   output logic [15:0]              target_ff,
   output logic [15:0]              target_in,
   output scr_pkg::frame_event_type events
);

   localparam int CW = $clog2(FRAME_LENGTH);

   logic [CW-1:0] count_ff, count_in;
   logic          recent_ff, recent_in;
   logic [7:0]    buf_ff [scr_pkg::CHECK_BYTES];
   logic [7:0]    byte3;
   logic          last_byte;

   // next state of the frame logic
   always_comb begin
      count_in  = count_ff;
      recent_in = recent_ff;
      target_in = target_ff;
      events    = '0;
      // byte 3 may be the byte arriving now when the frame is short
      byte3     = (count_ff == CW'(3)) ? item.rx_byte : buf_ff[3];
      last_byte = (count_ff == CW'(FRAME_LENGTH - 1));
      case (item.operation)
         scr_pkg::OP_BYTE: begin
            recent_in = 1'b1;
            if (last_byte) begin
               count_in = '0;
               if (buf_ff[0] == scr_pkg::FRAME_START && byte3 == scr_pkg::FRAME_END) begin
                  target_in             = {buf_ff[1], buf_ff[2]};
                  events.frame_accepted = 1'b1;
               end
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         scr_pkg::OP_POLL: begin
            if (recent_ff) begin
               recent_in = 1'b0;
            end else if (count_ff != '0) begin
               count_in               = '0;
               events.partial_cleared = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control state and target
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         recent_ff <= 1'b0;
         target_ff <= scr_pkg::RESET_TARGET;
      end else if (fire) begin
         count_ff  <= count_in;
         recent_ff <= recent_in;
         target_ff <= target_in;
      end
   end

   // frame byte buffer, no reset
   always_ff @(posedge clock) begin
      if (fire && item.operation == scr_pkg::OP_BYTE && int'(count_ff) < scr_pkg::CHECK_BYTES) begin
         buf_ff[count_ff[scr_pkg::BUF_IDX_W-1:0]] <= item.rx_byte;
      end
   end

endmodule

[design/scr_slew.sv]
// ---------------------------------------------------------------------------
// scr_slew
// Pulse width tracker: steps or jumps toward the target on each tick.
// ---------------------------------------------------------------------------
module scr_slew (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  scr_pkg::item_type item,
   input  logic              slew_enable,
   input  logic [15:0]       target,
   output logic [15:0]       current_ff,
   output logic [15:0]       current_in
);

   // next pulse width
   always_comb begin
      current_in = current_ff;
      if (item.operation == scr_pkg::OP_TICK) begin
         if (!slew_enable) begin
            current_in = target;
         end else if (current_ff < target) begin
            current_in = current_ff + 16'd1;
         end else if (current_ff > target) begin
            current_in = current_ff - 16'd1;
         end
      end
   end

   // pulse width register
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= scr_pkg::RESET_CURRENT;
      end else if (fire) begin
         current_ff <= current_in;
      end
   end

endmodule

[design/servo_command_receiver_slew.sv]
// ---------------------------------------------------------------------------
// servo_command_receiver_slew
// Servo command receiver with optional one-step-per-tick slew filter.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item per transfer: a received byte, a PWM
//   period tick or an idle poll (req_operation) with req_rx_byte.
//   rsp_ channel returns one result per item: compare value, target value
//   and the frame_accepted / partial_cleared flags, in item order.
//   csr_write_enable with csr_write_data sets slew_enable; write it only
//   while no item is in flight.
// Path: an item taken into the input register is applied to the state, and
//   its result is registered in the result register, which drives rsp_.
// Throughput: one item per cycle unless rsp_ stalls, set by the single state
//   update between the input register and the result register.
// Reset: synchronous; empties both stages, clears the byte counter and
//   idle flag, target 1000, pulse width 1520, slew off.
// Stall: with rsp_ready low the result register holds; the input register
//   still takes one more item, then req_ready drops.
// ---------------------------------------------------------------------------
module servo_command_receiver_slew #(
   parameter int FRAME_LENGTH = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_compare_value,
   output logic [15:0] rsp_target_value,
   output logic        rsp_frame_accepted,
   output logic        rsp_partial_cleared,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic                     slew_enable_ff;
   logic                     in_valid_ff;
   scr_pkg::item_type        in_item_ff;
   logic                     rsp_valid_ff;
   logic                     advance;
   logic                     stage_fire;
   logic [15:0]              target_ff;
   logic [15:0]              target_in;
   logic [15:0]              current_ff;
   logic [15:0]              current_in;
   scr_pkg::frame_event_type events;

   // stage control
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign stage_fire = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;
   assign rsp_valid  = rsp_valid_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         slew_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         slew_enable_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.operation <= req_operation;
         in_item_ff.rx_byte   <= req_rx_byte;
      end
   end

   // frame collector
   scr_frame #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .fire      (stage_fire),
      .item      (in_item_ff),
      .target_ff (target_ff),
      .target_in (target_in),
      .events    (events)
   );

   // pulse width tracker
   scr_slew u_slew (
      .clock       (clock),
      .reset       (reset),
      .fire        (stage_fire),
      .item        (in_item_ff),
      .slew_enable (slew_enable_ff),
      .target      (target_ff),
      .current_ff  (current_ff),
      .current_in  (current_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         rsp_compare_value   <= current_in;
         rsp_target_value    <= target_in;
         rsp_frame_accepted  <= events.frame_accepted;
         rsp_partial_cleared <= events.partial_cleared;
      end
   end

   // input side stalls only when both stages are full
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff))
      else $error("req_ready low with a free stage");

   // only a tick moves the pulse width
   a_width_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && in_item_ff.operation != scr_pkg::OP_TICK)
      |=> (rsp_compare_value == $past(current_ff)))
      else $error("pulse width changed on a non-tick item");

   // frame acceptance only on a byte
   a_accept_byte: assert property (@(posedge clock) disable iff (reset)
      (stage_fire && in_item_ff.operation != scr_pkg::OP_BYTE) |=> !rsp_frame_accepted)
      else $error("frame accepted on a non-byte item");

   // the two event flags never come together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_frame_accepted && rsp_partial_cleared))
      else $error("both event flags set");

endmodule

[bench/servo_status_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// servo_status_checker
// Watches the command and status channels of the servo command receiver,
// keeps its own copy of the frame buffer, target and pulse width, and checks
// every status transfer against the oldest predicted status.
// ---------------------------------------------------------------------------
module servo_status_checker #(
   parameter int FRAME_LENGTH = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_compare_value,
   input  logic [15:0] rsp_target_value,
   input  logic        rsp_frame_accepted,
   input  logic        rsp_partial_cleared,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output int          outstanding,
   output int          mismatches
);

   // one status item as the block reports it
   typedef struct packed {
      logic [15:0] compare_value;
      logic [15:0] target_value;
      logic        frame_accepted;
      logic        partial_cleared;
   } servo_status_type;

   // shadow state of the receiver
   logic [7:0]       frame_buf [FRAME_LENGTH];
   int               byte_cnt;
   logic             byte_seen;
   logic [15:0]      target_pw;
   logic [15:0]      current_pw;
   logic             slew_on;
   servo_status_type status_q [$];

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // apply one command to the shadow state and return the status it yields
   function automatic servo_status_type predict_status(input logic [1:0] op,
                                                       input logic [7:0] data);
      servo_status_type st;
      st = '0;
      case (scr_pkg::op_type'(op))
         scr_pkg::OP_BYTE: begin
            if (byte_cnt < FRAME_LENGTH)
               frame_buf[byte_cnt] = data;
            byte_cnt++;
            byte_seen = 1'b1;
            // full frame: take the target only from a well-formed H..R frame
            if (byte_cnt >= FRAME_LENGTH) begin
               if (frame_buf[0] == scr_pkg::FRAME_START &&
                   frame_buf[3] == scr_pkg::FRAME_END) begin
                  target_pw         = {frame_buf[1], frame_buf[2]};
                  st.frame_accepted = 1'b1;
               end
               byte_cnt = 0;
            end
         end
         scr_pkg::OP_TICK: begin
            if (slew_on) begin
               if (current_pw < target_pw)
                  current_pw = current_pw + 16'd1;
               else if (current_pw > target_pw)
                  current_pw = current_pw - 16'd1;
            end else begin
               current_pw = target_pw;
            end
         end
         scr_pkg::OP_POLL: begin
            // a byte since the last poll only re-arms the idle detector
            if (byte_seen)
               byte_seen = 1'b0;
            else if (byte_cnt != 0) begin
               byte_cnt           = 0;
               st.partial_cleared = 1'b1;
            end
         end
         default: ;
      endcase
      st.compare_value = current_pw;
      st.target_value  = target_pw;
      return st;
   endfunction

   // channel monitor: compare status transfers, then predict new commands
   always @(posedge clock) begin
      servo_status_type got;
      servo_status_type want;
      if (reset) begin
         byte_cnt   = 0;
         byte_seen  = 1'b0;
         target_pw  = scr_pkg::RESET_TARGET;
         current_pw = scr_pkg::RESET_CURRENT;
         slew_on    = 1'b0;
         status_q.delete();
      end else begin
         if (csr_write_enable)
            slew_on = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_compare_value, rsp_target_value,
                    rsp_frame_accepted, rsp_partial_cleared};
            if (status_q.size() == 0) begin
               report_mismatch($sformatf("status transfer with none pending (compare %0d)",
                                         got.compare_value));
            end else begin
               want = status_q.pop_front();
               check_field("compare_value", got.compare_value, want.compare_value);
               check_field("target_value", got.target_value, want.target_value);
               check_field("frame_accepted", got.frame_accepted, want.frame_accepted);
               check_field("partial_cleared", got.partial_cleared, want.partial_cleared);
            end
         end
         if (req_valid && req_ready)
            status_q.push_back(predict_status(req_operation, req_rx_byte));
      end
      outstanding <= status_q.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives commands into the servo command receiver: directed frames, ticks
// and polls first, then random frames, broken frames, tick bursts and noise
// under changing slew settings and idle patterns on both channels.
// ---------------------------------------------------------------------------
module testbench;

   localparam int         FRAME_LENGTH = 6;
   localparam int         RESET_CYCLES = 9;
   localparam int         STALL_LIMIT  = 5000;
   localparam int         DRAIN_SLACK  = 4;
   localparam int         PHASE_ITEMS  = 200;
   localparam int         PHASE_COUNT  = 6;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation    = scr_pkg::OP_BYTE;
   logic [7:0]  req_rx_byte      = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [15:0] rsp_compare_value;
   logic [15:0] rsp_target_value;
   logic        rsp_frame_accepted;
   logic        rsp_partial_cleared;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data   = 1'b0;

   int outstanding;
   int mismatches;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;

   servo_command_receiver_slew #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_compare_value   (rsp_compare_value),
      .rsp_target_value    (rsp_target_value),
      .rsp_frame_accepted  (rsp_frame_accepted),
      .rsp_partial_cleared (rsp_partial_cleared),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   servo_status_checker #(
      .FRAME_LENGTH (FRAME_LENGTH)
   ) u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_compare_value   (rsp_compare_value),
      .rsp_target_value    (rsp_target_value),
      .rsp_frame_accepted  (rsp_frame_accepted),
      .rsp_partial_cleared (rsp_partial_cleared),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .outstanding         (outstanding),
      .mismatches          (mismatches)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // status side backpressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: too long without any transfer ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else if (stall_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   // one command transfer, with random sender idle cycles ahead of it
   task automatic send_item(input logic [1:0] op, input logic [7:0] data);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_rx_byte   <= data;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      items_sent++;
   endtask

   // stop sending and wait for every pending status
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_slew(input logic value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(scr_pkg::OP_TICK, 8'($urandom_range(255)));
   endtask

   // pulse widths: many near the rest position so slewing can land on them
   function automatic logic [15:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 35)
         return 16'($urandom_range(1440, 1600));
      else if (r < 45)
         case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFE;
            default: return 16'hFFFF;
         endcase
      else
         return 16'($urandom_range(65535));
   endfunction

   // two polls always empty the buffer, then a full frame follows;
   // a broken frame has a bad start or end marker
   task automatic send_command_frame(input logic [15:0] width, input bit good);
      logic [7:0] frame [FRAME_LENGTH];
      int         bad_pos;
      send_item(scr_pkg::OP_POLL, 8'($urandom_range(255)));
      send_item(scr_pkg::OP_POLL, 8'($urandom_range(255)));
      foreach (frame[i]) frame[i] = 8'($urandom_range(255));
      frame[0] = scr_pkg::FRAME_START;
      frame[1] = width[15:8];
      frame[2] = width[7:0];
      frame[3] = scr_pkg::FRAME_END;
      if (!good) begin
         bad_pos = $urandom_range(1) ? 3 : 0;
         if (frame[bad_pos] == ((bad_pos == 0) ? scr_pkg::FRAME_START : scr_pkg::FRAME_END))
            frame[bad_pos] = 8'($urandom_range(255));
         if (frame[bad_pos] == ((bad_pos == 0) ? scr_pkg::FRAME_START : scr_pkg::FRAME_END))
            frame[bad_pos] = frame[bad_pos] ^ 8'h01;
      end
      foreach (frame[i]) begin
         send_item(scr_pkg::OP_BYTE, frame[i]);
         if ($urandom_range(99) < 20)
            send_ticks($urandom_range(1, 3));
      end
   endtask

   // unstructured commands, markers over-represented in the bytes
   task automatic send_noise(input int count);
      logic [7:0] data;
      repeat (count) begin
         case ($urandom_range(3))
            0: data = scr_pkg::FRAME_START;
            1: data = scr_pkg::FRAME_END;
            default: data = 8'($urandom_range(255));
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3, 4: send_item(scr_pkg::OP_BYTE, data);
            5, 6: send_item(scr_pkg::OP_TICK, data);
            7, 8: send_item(scr_pkg::OP_POLL, data);
            default: send_item(OP_UNUSED, data);
         endcase
      end
   endtask

   task automatic run_random(input int upto);
      int r;
      while (items_sent < upto) begin
         r = $urandom_range(99);
         if (r < 45)
            send_command_frame(pick_width(), 1'b1);
         else if (r < 55)
            send_command_frame(pick_width(), 1'b0);
         else if (r < 72)
            send_ticks($urandom_range(1, 40));
         else if (r < 80) begin
            // partial frame left to the idle detector
            repeat ($urandom_range(1, FRAME_LENGTH - 1))
               send_item(scr_pkg::OP_BYTE, 8'($urandom_range(255)));
            repeat ($urandom_range(1, 3))
               send_item(scr_pkg::OP_POLL, 8'($urandom_range(255)));
         end else if (r < 97)
            send_noise($urandom_range(1, 8));
         else
            drain_results();
      end
   endtask

   initial begin
      int phase_start;
      send_idle_pct = 17;
      recv_idle_pct = 86;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_slew(1'b0);

      // directed: unused selector, jump tick, empty poll
      send_item(OP_UNUSED, 8'hFF);
      send_item(scr_pkg::OP_TICK, 8'h00);
      send_item(scr_pkg::OP_POLL, 8'h00);
      // widest target, then jump to it
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_START);
      send_item(scr_pkg::OP_BYTE, 8'hFF);
      send_item(scr_pkg::OP_BYTE, 8'hFF);
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_END);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_BYTE, 8'hAA);
      send_item(scr_pkg::OP_TICK, 8'h55);
      // poll after a byte keeps the buffer, a second one clears it
      send_item(scr_pkg::OP_POLL, 8'hFF);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_POLL, 8'h00);
      send_item(scr_pkg::OP_POLL, 8'h00);
      // frame with markers swapped keeps the target
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_END);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_START);
      send_item(scr_pkg::OP_BYTE, 8'h01);
      send_item(scr_pkg::OP_BYTE, 8'h02);
      // zero target
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_START);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_BYTE, 8'h00);
      send_item(scr_pkg::OP_BYTE, scr_pkg::FRAME_END);
      send_item(scr_pkg::OP_BYTE, 8'h55);
      send_item(scr_pkg::OP_BYTE, 8'h55);
      send_item(scr_pkg::OP_TICK, 8'h00);

      // random phases: idle pattern changes every two phases, slew alternates
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_results();
         case (phase / 2)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_slew(phase % 2 == 1);
         phase_start = items_sent;
         run_random(phase_start + PHASE_ITEMS / 2);
         drain_results();
         run_random(phase_start + PHASE_ITEMS);
      end

      drain_results();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
design/scr_pkg.sv
design/scr_frame.sv
design/scr_slew.sv
design/servo_command_receiver_slew.sv
bench/servo_status_checker.sv
bench/testbench.sv
